// ===== hdl/ohm_pkg.sv =====
// Shared types, command and status codes, map size and the key hash step function.
// No dependencies; ohm_front, ohm_back and the top level in hdl import it.
`timescale 1ns / 1ps
package ohm_pkg;

    // Entry count; a power of two, so the bucket is the low bits of the hash
    localparam int CAPACITY = 256;
    localparam int AW       = $clog2(CAPACITY);
    localparam int IW       = $clog2(CAPACITY + 1);

    localparam logic [2:0] CMD_SET      = 3'd0;
    localparam logic [2:0] CMD_GET      = 3'd1;
    localparam logic [2:0] CMD_GET_NEW  = 3'd2;
    localparam logic [2:0] CMD_GET_OLD  = 3'd3;
    localparam logic [2:0] CMD_POP_KEY  = 3'd4;
    localparam logic [2:0] CMD_POP_NEW  = 3'd5;
    localparam logic [2:0] CMD_POP_OLD  = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam int unsigned HASH_STEPS  = 7;

    typedef struct packed {
        logic [2:0]  command;
        logic [63:0] key;
        logic [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] key_out;
        logic [31:0] value_out;
        logic [8:0]  entry_count;
    } t_out_item;

    // One round of the 64-bit shift-add-xor hash.
    function automatic logic [63:0] hash_step(input logic [63:0] k, input logic [2:0] s);
        logic [63:0] r;
        case (s)
            3'd0:    r = (~k) + (k << 21);
            3'd1:    r = k ^ (k >> 24);
            3'd2:    r = k + (k << 3) + (k << 8);
            3'd3:    r = k ^ (k >> 14);
            3'd4:    r = k + (k << 2) + (k << 4);
            3'd5:    r = k ^ (k >> 28);
            default: r = k + (k << 31);
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/ordered_hash_map_engine.sv =====
// Ordered hash map engine: top level joining front end, queue and back end.
// Depends on ohm_pkg, ohm_front, ohm_queue, ohm_back (and ohm_ram below it).
//
// Use: write a command word on i_in_item with push while full is low.
// Commands are set, get, get newest/oldest, pop by key and pop newest/oldest.
// Each command gives one result word on o_out_item, present while empty is
// low and taken with pop. The result carries status, key, value and the
// entry count after the command.
// Flow: the front end holds a word through accept, 7 hash rounds and hand-over,
// so it takes a new word only after handing the last one to the queue. The back end
// passes idle, dispatch, a bucket head read and one compare per chain entry, then
// its result steps (set update, get read, pop unlink and free, insert with an
// optional free-list read); a pop of newest/oldest adds a read, and a get of newest/oldest
// skips the walk. Front and back overlap; the slower one sets the rate.
// Reset: synchronous, active low. After it a sweep clears all 256
// bucket heads; full stays high meanwhile.
// Stall: a waiting result holds the back end in its last step while the
// front end and the two-word queue keep taking commands until they fill.
`timescale 1ns / 1ps
module ordered_hash_map_engine
    import ohm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item
);
    localparam int QW = $bits(t_in_item) + AW;

    logic          f_valid, q_ready, q_valid, take, clearing;
    t_in_item      f_item, q_item;
    logic [AW-1:0] f_bucket, q_bucket;

    ohm_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .i_item(i_in_item), .i_block(clearing),
        .o_full(full), .o_valid(f_valid), .o_item(f_item), .o_bucket(f_bucket),
        .i_ready(q_ready)
    );

    ohm_queue #(.WIDTH(QW)) u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_ready(q_ready),
        .i_data({f_item, f_bucket}), .o_valid(q_valid), .i_ready(take),
        .o_data({q_item, q_bucket})
    );

    ohm_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_item(q_item), .i_bucket(q_bucket),
        .o_take(take), .o_clearing(clearing), .o_empty(empty), .o_item(o_out_item),
        .i_pop(pop)
    );
endmodule

// ===== hdl/ohm_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ohm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wa,
    input  logic [WIDTH-1:0] i_wd,
    input  logic [AW-1:0]    i_ra,
    output logic [WIDTH-1:0] o_rd
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        o_rd <= r_mem[i_ra];
    end
endmodule

// ===== hdl/ohm_front.sv =====
// Front end: accepts command words, hashes the key and reduces it to a bucket.
// Depends on ohm_pkg.
`timescale 1ns / 1ps
module ohm_front
    import ohm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_in_item      i_item,
    input  logic          i_block,
    output logic          o_full,
    output logic          o_valid,
    output t_in_item      o_item,
    output logic [AW-1:0] o_bucket,
    input  logic          i_ready
);
    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_HASH = 3'b010,
        F_OUT  = 3'b100
    } t_fstate;

    t_fstate       r_state;
    t_in_item      r_item;
    logic [63:0]   r_h;
    logic [2:0]    r_step;
    logic [AW-1:0] r_b;
    logic [63:0]   n_h;

    assign n_h = hash_step(r_h, r_step);

    assign o_full   = (r_state != F_IDLE) || i_block;
    assign o_valid  = (r_state == F_OUT);
    assign o_item   = r_item;
    assign o_bucket = r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_push && !o_full) begin
                        r_item  <= i_item;
                        r_h     <= i_item.key;
                        r_step  <= '0;
                        r_state <= F_HASH;
                    end
                end
                F_HASH: begin
                    r_h    <= n_h;
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'(HASH_STEPS - 1)) begin
                        r_b     <= n_h[AW-1:0];
                        r_state <= F_OUT;
                    end
                end
                F_OUT: begin
                    if (i_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/ohm_queue.sv =====
// Two-word queue between front and back end.
// No dependencies.
`timescale 1ns / 1ps
module ohm_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_n;
    logic             n_wr;
    logic             n_rd;

    assign o_ready = (r_n != 2'd2);
    assign o_valid = (r_n != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign n_wr    = i_valid && o_ready;
    assign n_rd    = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_n  <= 2'd0;
        end else begin
            if (n_wr) r_wp <= ~r_wp;
            if (n_rd) r_rp <= ~r_rp;
            r_n <= r_n + 2'(n_wr) - 2'(n_rd);
        end
    end
endmodule

// ===== hdl/ohm_back.sv =====
// Back end: bucket chain walk, order list and free list upkeep, result register.
// Depends on ohm_pkg and ohm_ram.
`timescale 1ns / 1ps
module ohm_back
    import ohm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_in_item      i_item,
    input  logic [AW-1:0] i_bucket,
    output logic          o_take,
    output logic          o_clearing,
    output logic          o_empty,
    output t_out_item     o_item,
    input  logic          i_pop
);
    localparam logic [IW-1:0] NIL = IW'(CAPACITY);

    typedef enum logic [13:0] {
        S_CLR    = 14'b00000000000001,
        S_IDLE   = 14'b00000000000010,
        S_DISP   = 14'b00000000000100,
        S_ENDR   = 14'b00000000001000,
        S_W1     = 14'b00000000010000,
        S_W2     = 14'b00000000100000,
        S_GV     = 14'b00000001000000,
        S_RM1    = 14'b00000010000000,
        S_RM2    = 14'b00000100000000,
        S_ALLOC  = 14'b00001000000000,
        S_ALLOCR = 14'b00010000000000,
        S_INS1   = 14'b00100000000000,
        S_INS2   = 14'b01000000000000,
        S_RES    = 14'b10000000000000
    } t_bstate;

    t_bstate       r_state;
    logic [2:0]    r_cmd;
    logic [63:0]   r_key;
    logic [31:0]   r_val;
    logic [AW-1:0] r_b;
    logic [IW-1:0] r_cur, r_prev, r_nxt, r_bh;
    logic [IW-1:0] r_newest, r_oldest, r_free, r_fresh, r_count, r_clr;
    logic [1:0]    r_rs;
    logic [63:0]   r_rk;
    logic [31:0]   r_rv;
    logic          r_ov;
    t_out_item     r_out;

    logic          bh_we, cn_we, ky_we, vl_we, eb_we, on_we, op_we;
    logic [AW-1:0] bh_wa, cn_wa, ky_wa, vl_wa, eb_wa, on_wa, op_wa;
    logic [AW-1:0] bh_ra, cn_ra, ky_ra, vl_ra, eb_ra, on_ra, op_ra;
    logic [IW-1:0] bh_wd, cn_wd, on_wd, op_wd;
    logic [IW-1:0] bh_rd, cn_rd, on_rd, op_rd;
    logic [63:0]   ky_rd;
    logic [31:0]   vl_wd, vl_rd;
    logic [AW-1:0] eb_rd;
    logic [IW-1:0] n_sel;
    logic          n_ends;
    logic          n_match;
    logic          n_slot;

    ohm_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_bh (.i_clk, .i_we(bh_we), .i_wa(bh_wa),
        .i_wd(bh_wd), .i_ra(bh_ra), .o_rd(bh_rd));
    ohm_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_cn (.i_clk, .i_we(cn_we), .i_wa(cn_wa),
        .i_wd(cn_wd), .i_ra(cn_ra), .o_rd(cn_rd));
    ohm_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_ky (.i_clk, .i_we(ky_we), .i_wa(ky_wa),
        .i_wd(r_key), .i_ra(ky_ra), .o_rd(ky_rd));
    ohm_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_vl (.i_clk, .i_we(vl_we), .i_wa(vl_wa),
        .i_wd(vl_wd), .i_ra(vl_ra), .o_rd(vl_rd));
    ohm_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_eb (.i_clk, .i_we(eb_we), .i_wa(eb_wa),
        .i_wd(r_b), .i_ra(eb_ra), .o_rd(eb_rd));
    ohm_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_on (.i_clk, .i_we(on_we), .i_wa(on_wa),
        .i_wd(on_wd), .i_ra(on_ra), .o_rd(on_rd));
    ohm_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_op (.i_clk, .i_we(op_we), .i_wa(op_wa),
        .i_wd(op_wd), .i_ra(op_ra), .o_rd(op_rd));

    assign n_sel   = (r_cmd == CMD_GET_NEW || r_cmd == CMD_POP_NEW) ? r_newest : r_oldest;
    assign n_ends  = (r_cmd == CMD_GET_NEW) || (r_cmd == CMD_GET_OLD) ||
                     (r_cmd == CMD_POP_NEW) || (r_cmd == CMD_POP_OLD);
    assign n_match = (ky_rd == r_key);
    assign n_slot  = !r_ov || i_pop;

    assign o_take     = (r_state == S_IDLE) && i_valid;
    assign o_clearing = (r_state == S_CLR);
    assign o_empty    = !r_ov;
    assign o_item     = r_out;

    always_comb begin
        bh_we = 1'b0; cn_we = 1'b0; ky_we = 1'b0; vl_we = 1'b0;
        eb_we = 1'b0; on_we = 1'b0; op_we = 1'b0;
        bh_wa = r_b;  cn_wa = r_cur[AW-1:0]; ky_wa = r_cur[AW-1:0];
        vl_wa = r_cur[AW-1:0]; eb_wa = r_cur[AW-1:0];
        on_wa = r_cur[AW-1:0]; op_wa = r_cur[AW-1:0];
        bh_wd = NIL;  cn_wd = r_bh; on_wd = r_newest; op_wd = NIL; vl_wd = r_val;
        bh_ra = r_b;  cn_ra = r_cur[AW-1:0]; ky_ra = r_cur[AW-1:0];
        vl_ra = r_cur[AW-1:0]; eb_ra = r_cur[AW-1:0];
        on_ra = r_cur[AW-1:0]; op_ra = r_cur[AW-1:0];
        unique case (r_state)
            S_CLR: begin
                bh_we = 1'b1;
                bh_wa = r_clr[AW-1:0];
            end
            S_DISP: begin
                ky_ra = n_sel[AW-1:0];
                vl_ra = n_sel[AW-1:0];
                eb_ra = n_sel[AW-1:0];
            end
            S_ENDR: bh_ra = eb_rd;
            S_W1: begin
                ky_ra = bh_rd[AW-1:0];
                cn_ra = bh_rd[AW-1:0];
            end
            S_W2: begin
                ky_ra = cn_rd[AW-1:0];
                cn_ra = cn_rd[AW-1:0];
                vl_we = n_match && (r_cmd == CMD_SET);
            end
            S_RM1: begin
                // unlink from the bucket chain
                if (r_prev != NIL) begin
                    cn_we = 1'b1;
                    cn_wa = r_prev[AW-1:0];
                    cn_wd = r_nxt;
                end else begin
                    bh_we = 1'b1;
                    bh_wd = r_nxt;
                end
            end
            S_RM2: begin
                on_we = (op_rd != NIL);
                on_wa = op_rd[AW-1:0];
                on_wd = on_rd;
                op_we = (on_rd != NIL);
                op_wa = on_rd[AW-1:0];
                op_wd = op_rd;
                cn_we = 1'b1;
                cn_wd = r_free;
            end
            S_ALLOC: cn_ra = r_free[AW-1:0];
            S_INS1: begin
                cn_we = 1'b1;
                bh_we = 1'b1;
                bh_wd = r_cur;
                on_we = 1'b1;
                ky_we = 1'b1;
                vl_we = 1'b1;
                eb_we = 1'b1;
                op_we = (r_newest != NIL);
                op_wa = r_newest[AW-1:0];
                op_wd = r_cur;
            end
            S_INS2: op_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_newest <= NIL;
            r_oldest <= NIL;
            r_free   <= '0;
            r_fresh  <= '0;
            r_count  <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (r_state == S_RES && n_slot) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + IW'(1);
                    if (r_clr == NIL - IW'(1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd   <= i_item.command;
                        r_key   <= i_item.key;
                        r_val   <= i_item.value;
                        r_b     <= i_bucket;
                        r_rs    <= ST_OK;
                        r_rk    <= '0;
                        r_rv    <= '0;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    if (n_ends) begin
                        if (n_sel == NIL) begin
                            r_rs    <= ST_EMPTY;
                            r_state <= S_RES;
                        end else begin
                            r_state <= S_ENDR;
                        end
                    end else if (r_cmd == CMD_SET || r_cmd == CMD_GET ||
                                 r_cmd == CMD_POP_KEY) begin
                        r_state <= S_W1;
                    end else begin
                        r_state <= S_RES;
                    end
                end
                S_ENDR: begin
                    if (r_cmd == CMD_GET_NEW || r_cmd == CMD_GET_OLD) begin
                        r_rk    <= ky_rd;
                        r_rv    <= vl_rd;
                        r_state <= S_RES;
                    end else begin
                        // walk the chain for the entry's own key
                        r_key   <= ky_rd;
                        r_b     <= eb_rd;
                        r_state <= S_W1;
                    end
                end
                S_W1: begin
                    r_bh   <= bh_rd;
                    r_prev <= NIL;
                    r_cur  <= bh_rd;
                    if (bh_rd != NIL) begin
                        r_state <= S_W2;
                    end else if (r_cmd != CMD_SET) begin
                        r_rs    <= ST_NOT_FOUND;
                        r_state <= S_RES;
                    end else if (r_free == NIL) begin
                        r_rs    <= ST_FULL;
                        r_state <= S_RES;
                    end else begin
                        r_state <= S_ALLOC;
                    end
                end
                S_W2: begin
                    if (n_match) begin
                        r_nxt <= cn_rd;
                        if (r_cmd == CMD_SET) r_state <= S_RES;
                        else if (r_cmd == CMD_GET) r_state <= S_GV;
                        else r_state <= S_RM1;
                    end else begin
                        r_prev <= r_cur;
                        r_cur  <= cn_rd;
                        if (cn_rd != NIL) begin
                            r_state <= S_W2;
                        end else if (r_cmd != CMD_SET) begin
                            r_rs    <= ST_NOT_FOUND;
                            r_state <= S_RES;
                        end else if (r_free == NIL) begin
                            r_rs    <= ST_FULL;
                            r_state <= S_RES;
                        end else begin
                            r_state <= S_ALLOC;
                        end
                    end
                end
                S_GV: begin
                    r_rk    <= r_key;
                    r_rv    <= vl_rd;
                    r_state <= S_RES;
                end
                S_RM1: r_state <= S_RM2;
                S_RM2: begin
                    if (op_rd == NIL) r_newest <= on_rd;
                    if (on_rd == NIL) r_oldest <= op_rd;
                    r_free  <= r_cur;
                    r_count <= r_count - IW'(1);
                    r_rk    <= r_key;
                    r_rv    <= vl_rd;
                    r_state <= S_RES;
                end
                S_ALLOC: begin
                    r_cur <= r_free;
                    // a never-used entry links to the next index
                    if (r_free == r_fresh) begin
                        r_free  <= r_fresh + IW'(1);
                        r_fresh <= r_fresh + IW'(1);
                        r_state <= S_INS1;
                    end else begin
                        r_state <= S_ALLOCR;
                    end
                end
                S_ALLOCR: begin
                    r_free  <= cn_rd;
                    r_state <= S_INS1;
                end
                S_INS1: begin
                    if (r_newest == NIL) r_oldest <= r_cur;
                    r_state <= S_INS2;
                end
                S_INS2: begin
                    r_newest <= r_cur;
                    r_count  <= r_count + IW'(1);
                    r_state  <= S_RES;
                end
                S_RES: begin
                    if (n_slot) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RES && n_slot) begin
            r_out <= '{status: r_rs, key_out: r_rk, value_out: r_rv,
                       entry_count: 9'(r_count)};
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NIL)
        else $error("entry count beyond capacity");
    a_ends_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_newest == NIL) == (r_oldest == NIL)))
        else $error("order list ends disagree");
    a_free_exhausted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_free == NIL) |-> (r_count == NIL))
        else $error("free list empty while map not full");
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_newest == NIL) |-> (r_count == '0))
        else $error("order list empty with entries counted");
endmodule

// ===== tb/tb.sv =====
// Self-checking bench for ordered_hash_map_engine: a clocked driver and monitor,
// and a predictor of the ordered hash map that the DUT is checked against.
// Depends on ohm_pkg and the RTL under hdl.
`timescale 1ns / 1ps
module tb;
    import ohm_pkg::*;

    localparam int          CAP        = CAPACITY;
    localparam logic [8:0]  NIL        = 9'd256;
    localparam logic [2:0]  CMD_UNUSED = 3'd7;
    localparam int          CYCLE_MAX  = 400000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    logic      full;
    logic      empty;
    t_in_item  in_word = '0;
    t_out_item out_word;

    ordered_hash_map_engine DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (in_word),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (out_word)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the map
    logic [63:0] m_key   [CAP];
    logic [31:0] m_val   [CAP];
    logic [8:0]  m_chain [CAP];
    logic [8:0]  m_onext [CAP];
    logic [8:0]  m_oprev [CAP];
    logic [8:0]  m_bucket[CAP];
    logic [8:0]  m_newest, m_oldest, m_free, m_count;

    t_in_item    cmd_q[$];
    t_out_item   result_q[$];
    logic [63:0] known_keys[$];
    int          sent = 0;
    int          fails = 0;
    int          cycles = 0;
    int          tx_idle, rx_idle;

    function automatic logic [7:0] bucket_of_key(logic [63:0] k);
        logic [63:0] h;
        h = (~k) + (k << 21);
        h = h ^ (h >> 24);
        h = h + (h << 3) + (h << 8);
        h = h ^ (h >> 14);
        h = h + (h << 2) + (h << 4);
        h = h ^ (h >> 28);
        h = h + (h << 31);
        return h[7:0];
    endfunction

    function automatic logic [8:0] find_entry(logic [63:0] k, output logic [8:0] prev);
        logic [8:0] c;
        int         guard;
        c = m_bucket[bucket_of_key(k)];
        prev = NIL;
        guard = 0;
        while (c != NIL && guard <= CAP) begin
            if (m_key[c[7:0]] == k) return c;
            prev = c;
            c = m_chain[c[7:0]];
            guard++;
        end
        prev = NIL;
        return NIL;
    endfunction

    function automatic logic [8:0] unlink_entry(logic [63:0] k);
        logic [8:0] prev, e, np, nn;
        e = find_entry(k, prev);
        if (e == NIL) return NIL;
        if (prev != NIL) m_chain[prev[7:0]] = m_chain[e[7:0]];
        else m_bucket[bucket_of_key(k)] = m_chain[e[7:0]];
        np = m_oprev[e[7:0]];
        nn = m_onext[e[7:0]];
        if (np != NIL) m_onext[np[7:0]] = nn;
        else m_newest = nn;
        if (nn != NIL) m_oprev[nn[7:0]] = np;
        else m_oldest = np;
        m_chain[e[7:0]] = m_free;
        m_free = e;
        if (m_count > 0) m_count--;
        return e;
    endfunction

    function automatic void map_clear();
        for (int i = 0; i < CAP; i++) begin
            m_chain[8'(i)]  = (i == CAP - 1) ? NIL : 9'(i + 1);
            m_onext[8'(i)]  = NIL;
            m_oprev[8'(i)]  = NIL;
            m_bucket[8'(i)] = NIL;
        end
        m_newest = NIL;
        m_oldest = NIL;
        m_free   = 9'd0;
        m_count  = 9'd0;
    endfunction

    function automatic t_out_item map_apply(t_in_item w);
        t_out_item  r;
        logic [8:0] prev, e;
        logic [7:0] b;
        logic [63:0] k;
        r = '0;
        case (w.command) inside
            CMD_SET: begin
                b = bucket_of_key(w.key);
                e = find_entry(w.key, prev);
                if (e != NIL) begin
                    m_val[e[7:0]] = w.value;
                end else if (m_free == NIL) begin
                    r.status = ST_FULL;
                end else begin
                    e = m_free;
                    m_free = m_chain[e[7:0]];
                    m_chain[e[7:0]] = m_bucket[b];
                    m_bucket[b] = e;
                    if (m_newest != NIL) m_oprev[m_newest[7:0]] = e;
                    else m_oldest = e;
                    m_oprev[e[7:0]] = NIL;
                    m_onext[e[7:0]] = m_newest;
                    m_newest = e;
                    m_count++;
                    m_key[e[7:0]] = w.key;
                    m_val[e[7:0]] = w.value;
                end
            end
            CMD_GET: begin
                e = find_entry(w.key, prev);
                if (e != NIL) begin
                    r.key_out = w.key;
                    r.value_out = m_val[e[7:0]];
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            CMD_GET_NEW, CMD_GET_OLD: begin
                e = (w.command == CMD_GET_NEW) ? m_newest : m_oldest;
                if (e != NIL) begin
                    r.key_out = m_key[e[7:0]];
                    r.value_out = m_val[e[7:0]];
                end else begin
                    r.status = ST_EMPTY;
                end
            end
            CMD_POP_KEY, CMD_POP_NEW, CMD_POP_OLD: begin
                k = w.key;
                e = NIL;
                if (w.command == CMD_POP_NEW) e = m_newest;
                if (w.command == CMD_POP_OLD) e = m_oldest;
                if (w.command != CMD_POP_KEY && e == NIL) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (w.command != CMD_POP_KEY) k = m_key[e[7:0]];
                    e = unlink_entry(k);
                    if (e != NIL) begin
                        r.key_out = k;
                        r.value_out = m_val[e[7:0]];
                    end else begin
                        r.status = ST_NOT_FOUND;
                    end
                end
            end
            default: ;
        endcase
        r.entry_count = m_count;
        return r;
    endfunction

    function automatic logic [63:0] rand_key64();
        return {$urandom, $urandom};
    endfunction

    // Known keys but for a fresh_pct share of new ones, so that hits, updates and removals are common
    function automatic logic [63:0] pick_key(int fresh_pct);
        logic [63:0] k;
        if (known_keys.size() == 0 || $urandom_range(99) < fresh_pct) begin
            k = rand_key64();
            known_keys.push_back(k);
            return k;
        end
        return known_keys[$urandom_range(known_keys.size() - 1)];
    endfunction

    function automatic void add_cmd(logic [2:0] c, logic [63:0] k, logic [31:0] v);
        t_in_item w;
        w.command = c;
        w.key = k;
        w.value = v;
        cmd_q.push_back(w);
    endfunction

    // set_pct: share of sets; the remainder spreads over codes 1 to 7, the unused code 7 among them
    function automatic void add_random(int n, int set_pct, int fresh_pct);
        logic [2:0] c;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < set_pct) c = CMD_SET;
            else c = 3'($urandom_range(7, 1));
            add_cmd(c, pick_key(fresh_pct), $urandom);
        end
    endfunction

    always_comb begin
        if (sent < 180) begin
            tx_idle = 7;
            rx_idle = 62;
        end else if (sent < 360) begin
            tx_idle = 62;
            rx_idle = 7;
        end else begin
            tx_idle = 0;
            rx_idle = 0;
        end
    end

    // Driver: predict on acceptance, then load the next word or hold
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                result_q.push_back(map_apply(in_word));
                sent++;
            end
            if (!push || !full) begin
                if (cmd_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
                    push <= 1'b1;
                    in_word <= cmd_q.pop_front();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each taken result against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item exp_w;
        if (i_rst_n && pop && !empty) begin
            if (result_q.size() == 0) begin
                fails++;
                if (fails <= 10) $display("unexpected result word %h", out_word);
            end else begin
                exp_w = result_q.pop_front();
                if (exp_w !== out_word) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("mismatch: exp st=%0d k=%h v=%h n=%0d",
                                 exp_w.status, exp_w.key_out, exp_w.value_out,
                                 exp_w.entry_count);
                        $display("          got st=%0d k=%h v=%h n=%0d",
                                 out_word.status, out_word.key_out,
                                 out_word.value_out, out_word.entry_count);
                    end
                end
            end
        end
        pop <= ($urandom_range(99) >= rx_idle);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_MAX) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        logic [63:0] ka, kb;
        map_clear();
        ka = 64'd0;
        kb = '1;
        // Empty map: every read and removal must report missing or empty
        add_cmd(CMD_GET, ka, '1);
        add_cmd(CMD_GET_NEW, ka, 32'd0);
        add_cmd(CMD_GET_OLD, kb, 32'd0);
        add_cmd(CMD_POP_KEY, kb, 32'd0);
        add_cmd(CMD_POP_NEW, ka, 32'd0);
        add_cmd(CMD_POP_OLD, ka, 32'd0);
        add_cmd(CMD_UNUSED, kb, '1);
        add_cmd(CMD_SET, ka, 32'd0);
        add_cmd(CMD_SET, kb, '1);
        add_cmd(CMD_SET, 64'h8000_0000_0000_0001, 32'h8000_0001);
        add_cmd(CMD_SET, ka, 32'h1234_5678);
        add_cmd(CMD_GET, ka, 32'd0);
        add_cmd(CMD_GET, kb, 32'd0);
        add_cmd(CMD_GET, 64'd5, 32'd0);
        add_cmd(CMD_GET_NEW, ka, 32'd0);
        add_cmd(CMD_GET_OLD, ka, 32'd0);
        add_cmd(CMD_UNUSED, ka, 32'd0);
        add_cmd(CMD_POP_KEY, kb, 32'd0);
        add_cmd(CMD_POP_KEY, kb, 32'd0);
        add_cmd(CMD_POP_NEW, ka, 32'd0);
        add_cmd(CMD_POP_OLD, ka, 32'd0);
        add_cmd(CMD_POP_OLD, ka, 32'd0);
        add_random(40, 40, 40);
        // Fill past capacity so that inserts hit the full case, then mostly reads and removals
        add_random(280, 97, 100);
        add_random(60, 10, 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (cmd_q.size() == 0 && !push && result_q.size() == 0);
        repeat (50) @(posedge i_clk);
        if (fails == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
